// ===== rtl/core/gjdc_pkg.sv =====
// Shared types, constants and helper functions of the Gregorian / Julian day converter.
package gjdc_pkg;

  // Field widths of the input and result items.
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned YearW    = 14;
  localparam int unsigned JdnW     = 23;
  localparam int unsigned WdayW    = 3;
  localparam int unsigned DoyW     = 9;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutPadW  = OutDataW - (JdnW + MonthW + DayW + YearW + WdayW + DoyW);

  // Shifted year: year - 1 + 4800 keeps every term of the day count non-negative.
  localparam logic [YearW:0] YearBias = 15'd4799;

  // Reciprocal of 25 scaled by 2^17; exact for dividends below 43690.
  localparam logic [12:0] Recip25  = 13'd5243;
  localparam int unsigned RecipShift = 17;

  // Day number of 1 January is 365*Y + Y/4 - Y/100 + Y/400 - Jan1Offset.
  localparam logic [JdnW-1:0] Jan1Offset = 23'd31738;

  // Fallback date, 11 May 1959.
  localparam logic [JdnW-1:0]   DefJdn   = 23'd2436700;
  localparam logic [MonthW-1:0] DefMonth = 4'd5;
  localparam logic [DayW-1:0]   DefDay   = 5'd11;
  localparam logic [YearW-1:0]  DefYear  = 14'd1959;
  localparam logic [WdayW-1:0]  DefWday  = 3'd0;
  localparam logic [DoyW-1:0]   DefDoy   = 9'd131;

  // Month codes used by the tables.
  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  // Stage 1 payload: input fields and the first products.
  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
    logic [25:0]       prod_shift;  // (Y/4) * Recip25
    logic [24:0]       prod_year;   // (year/4) * Recip25
    logic [JdnW-1:0]   base;        // 365*Y + Y/4 - Jan1Offset
  } s1_t;

  // Stage 2 payload: validity, day of year and day number of 1 January.
  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
    logic              ok;
    logic [DoyW-1:0]   doy;
    logic [JdnW-1:0]   jan1;
  } s2_t;

  // Stage 3 and output payload: the chosen date.
  typedef struct packed {
    logic [JdnW-1:0]   jdn;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
    logic [DoyW-1:0]   doy;
    logic              ok;
  } s3_t;

  // Days in the year before the first of a month.
  function automatic logic [DoyW-1:0] days_before(logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month; zero for codes that are not a month.
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Remainder modulo 7 by folding octal digits, since 8 is 1 modulo 7.
  function automatic logic [WdayW-1:0] mod7(logic [JdnW-1:0] v);
    logic [JdnW:0] ext;
    logic [5:0]    s1;
    logic [3:0]    s2;
    logic [3:0]    s3;
    ext = {1'b0, v};
    s1  = '0;
    for (int i = 0; i < (JdnW + 1) / 3; i++) begin
      s1 = s1 + 6'(ext[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    return (s3 == 4'd7) ? 3'd0 : s3[2:0];
  endfunction

endpackage

// ===== rtl/core/gregorian_julian_day_converter_unit.sv =====
// Top level: four-stage pipeline turning a Gregorian date into its checked Julian day record.
//
// Usage:
//   Input channel s_axis_*: one transfer carries a month, day and year.
//   Output channel m_axis_*: one transfer carries the chosen day number, its
//   month, day and year, the weekday (0 Monday) and the day of year; tuser is
//   high when the input date was a real calendar date and low when the
//   default date 11 May 1959 was substituted.
//   An input transfer passes through four register stages to the output
//   register: shifted-year products, century correction and validity, day
//   number select, weekday fold into the output register. Throughput is one
//   date per cycle while the receiver keeps m_axis_tready high.
//   Every stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up while the receiver stalls.
//   When m_axis_tready stays low the four stages fill and s_axis_tready drops;
//   nothing is lost or repeated and the output holds steady.
//   Reset clears all valid bits; the block needs no warm-up after reset.
module gregorian_julian_day_converter_unit
  import gjdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // month_in[3:0], day_in[8:4], year_in[22:9]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // julian_day, month_out, day_out,
                                              // year_out, weekday, day_of_year
  output logic                m_axis_tuser    // date_valid
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q, s4_q;
  logic [WdayW-1:0] wday_d, wday_q;

  logic [MonthW-1:0] in_month;
  logic [DayW-1:0]   in_day;
  logic [YearW-1:0]  in_year;
  logic [YearW:0]    shift_year;

  logic [8:0]        q_shift;
  logic [7:0]        q_year;
  logic [YearW-1:0]  year_rem;
  logic              leap;
  logic [DayW-1:0]   mlen;

  // A stage may load when it is empty or its contents move on.
  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  // Stage 1: shifted year, base day count and the products for the divisions by 100.
  assign in_month   = s_axis_tdata[3:0];
  assign in_day     = s_axis_tdata[8:4];
  assign in_year    = s_axis_tdata[22:9];
  assign shift_year = {1'b0, in_year} + YearBias;

  always_comb begin
    s1_d.month      = in_month;
    s1_d.day        = in_day;
    s1_d.year       = in_year;
    s1_d.prod_shift = 26'(shift_year[YearW:2]) * 26'(Recip25);
    s1_d.prod_year  = 25'(in_year[YearW-1:2]) * 25'(Recip25);
    s1_d.base       = JdnW'(shift_year) * 23'd365 + JdnW'(shift_year[YearW:2]) - Jan1Offset;
  end

  // Stage 2: century terms, leap year, date check and day of year.
  assign q_shift  = s1_q.prod_shift[25:RecipShift];
  assign q_year   = s1_q.prod_year[24:RecipShift];
  assign year_rem = s1_q.year - YearW'(q_year) * 14'd100;
  assign leap     = (s1_q.year[1:0] == 2'd0) && ((year_rem != '0) || (q_year[1:0] == 2'd0));
  assign mlen     = month_len(s1_q.month, leap);

  always_comb begin
    s2_d.month = s1_q.month;
    s2_d.day   = s1_q.day;
    s2_d.year  = s1_q.year;
    s2_d.ok    = (s1_q.month >= MonJan) && (s1_q.month <= MonDec) &&
                 (s1_q.day != '0) && (s1_q.day <= mlen);
    s2_d.doy   = days_before(s1_q.month) + DoyW'(s1_q.day) +
                 DoyW'(leap && (s1_q.month > MonFeb));
    s2_d.jan1  = s1_q.base - JdnW'(q_shift) + JdnW'(q_shift[8:2]);
  end

  // Stage 3: pick the day number of the input date or of the default date.
  always_comb begin
    s3_d.ok = s2_q.ok;
    if (s2_q.ok) begin
      s3_d.jdn   = s2_q.jan1 + JdnW'(s2_q.doy) - 23'd1;
      s3_d.month = s2_q.month;
      s3_d.day   = s2_q.day;
      s3_d.year  = s2_q.year;
      s3_d.doy   = s2_q.doy;
    end else begin
      s3_d.jdn   = DefJdn;
      s3_d.month = DefMonth;
      s3_d.day   = DefDay;
      s3_d.year  = DefYear;
      s3_d.doy   = DefDoy;
    end
  end

  // Stage 4: weekday from the day number.
  assign wday_d = mod7(s3_q.jdn);

  // Valid bits of the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Payload registers load only with a valid item.
  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) s1_q <= s1_d;
    if (rdy2 && v1_q)          s2_q <= s2_d;
    if (rdy3 && v2_q)          s3_q <= s3_d;
    if (rdy4 && v3_q) begin
      s4_q   <= s3_q;
      wday_q <= wday_d;
    end
  end

  // Output register drives the result channel.
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, s4_q.doy, wday_q, s4_q.year,
                          s4_q.day, s4_q.month, s4_q.jdn};
  assign m_axis_tuser  = s4_q.ok;

endmodule

// ===== rtl/core/gjdc_checker.sv =====
// Port-level checker of the converter and its bind to the top level.
module gjdc_checker
  import gjdc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  logic [MonthW-1:0] mon;
  logic [DayW-1:0]   dom;
  logic [WdayW-1:0]  wd;
  logic [DoyW-1:0]   doy;

  assign mon = m_axis_tdata[26:23];
  assign dom = m_axis_tdata[31:27];
  assign wd  = m_axis_tdata[48:46];
  assign doy = m_axis_tdata[57:49];

  // A stalled result keeps its data and flag.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A rejected date reports exactly the default record.
  a_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata[22:0] == DefJdn) && (mon == DefMonth) && (dom == DefDay) &&
      (m_axis_tdata[45:32] == DefYear) && (wd == DefWday) && (doy == DefDoy))
    else $error("invalid date without default record");

  // An accepted date reports fields in calendar range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (mon >= 4'd1) && (mon <= 4'd12) && (dom >= 5'd1) && (wd <= 3'd6) &&
      (doy >= 9'd1) && (doy <= 9'd366) && (m_axis_tdata[63:58] == 6'd0))
    else $error("valid date out of range");

endmodule

bind gregorian_julian_day_converter_unit gjdc_checker u_gjdc_checker (.*);
